FILE: design/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP_FWD   = 3'd4,
    OP_DUMP_BWD   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_ROT_FWD,
    CMD_ROT_BWD
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] last_idx;
  } cell_ctrl_t;

endpackage

FILE: design/double_ended_queue_top.sv
// Double-ended queue: control, output register and the chain of storage cells.
// Push, pop and unused ops: one request per cycle while the output is not stalled, result registered in the next cycle.
// Dumps: one result per held entry, one per cycle while the output is not stalled; the chain
// rotates once per result, and input stays stalled until the last entry is out.
// Reset (rst_ni low, asynchronous) empties the queue; cell contents are not cleared.
module double_ended_queue_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        in_op_i,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [deq_pkg::DATA_W-1:0] out_item_o,
  output logic [1:0]                        out_status_o,
  output logic [deq_pkg::CNT_W-1:0]         out_occupancy_o,
  output logic                              out_last_of_run_o
);
  import deq_pkg::*;

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     dumping_q, dumping_d;
  logic                     dump_fwd_q, dump_fwd_d;
  logic [CNT_W-1:0]         left_q, left_d;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_item_q;
  logic [1:0]               out_status_q;
  logic [CNT_W-1:0]         out_occ_q;
  logic                     out_last_q;

  logic                     out_free, accept, load;
  logic signed [DATA_W-1:0] item_d;
  status_e                  status_d;
  logic                     last_d;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] head, tail;
  logic [CNT_W-1:0]         last_idx;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = dumping_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign last_idx = count_q - CNT_W'(1);
  assign head     = cell_data[0];
  assign tail     = cell_data[last_idx[IDX_W-1:0]];

  always_comb begin
    ctrl.cmd      = CMD_HOLD;
    ctrl.count    = count_q;
    ctrl.last_idx = last_idx;
    count_d       = count_q;
    dumping_d     = dumping_q;
    dump_fwd_d    = dump_fwd_q;
    left_d        = left_q;
    load          = 1'b0;
    item_d        = '0;
    status_d      = ST_OK;
    last_d        = 1'b1;
    if (dumping_q) begin
      if (out_free) begin
        load      = 1'b1;
        item_d    = dump_fwd_q ? head : tail;
        ctrl.cmd  = dump_fwd_q ? CMD_ROT_FWD : CMD_ROT_BWD;
        last_d    = (left_q == CNT_W'(1));
        left_d    = left_q - CNT_W'(1);
        dumping_d = (left_q != CNT_W'(1));
      end
    end else if (accept) begin
      load = 1'b1;
      case (op_e'(in_op_i))
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (count_q == DEPTH_CNT) begin
            status_d = ST_FULL;
          end else begin
            ctrl.cmd = (op_e'(in_op_i) == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            // pop back needs no movement: the tail slot just drops out of the window
            if (op_e'(in_op_i) == OP_POP_FRONT) begin
              ctrl.cmd = CMD_POP_FRONT;
              item_d   = head;
            end else begin
              item_d   = tail;
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_DUMP_FWD, OP_DUMP_BWD: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            dump_fwd_d = (op_e'(in_op_i) == OP_DUMP_FWD);
            item_d     = dump_fwd_d ? head : tail;
            ctrl.cmd   = dump_fwd_d ? CMD_ROT_FWD : CMD_ROT_BWD;
            last_d     = (count_q == CNT_W'(1));
            left_d     = last_idx;
            dumping_d  = (count_q != CNT_W'(1));
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dumping_q   <= 1'b0;
      dump_fwd_q  <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      dumping_q  <= dumping_d;
      dump_fwd_q <= dump_fwd_d;
      left_q     <= left_d;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q   <= item_d;
      out_status_q <= status_d;
      out_occ_q    <= count_d;
      out_last_q   <= last_d;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = in_value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    deq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .value_i (in_value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (head),
      .tail_i  (tail),
      .data_o  (cell_data[g])
    );
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;
  assign out_status_o      = out_status_q;
  assign out_occupancy_o   = out_occ_q;
  assign out_last_of_run_o = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count exceeds depth");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dumping_q |-> (count_q != '0) && in_stall_o)
    else $error("dump running on empty queue or input not stalled");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op_i == OP_PUSH_FRONT || in_op_i == OP_PUSH_BACK)
     && count_q != DEPTH_CNT) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow the queue");

  a_dump_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dumping_q |=> count_q == $past(count_q))
    else $error("occupancy changed during dump");

endmodule

FILE: design/deq_cell.sv
// One storage cell of the queue chain; position 0 is the front.
module deq_cell (
  input  logic                              clk_i,
  input  deq_pkg::cell_ctrl_t               ctrl_i,
  input  logic [deq_pkg::IDX_W-1:0]         idx_i,
  input  logic signed [deq_pkg::DATA_W-1:0] value_i,
  input  logic signed [deq_pkg::DATA_W-1:0] left_i,
  input  logic signed [deq_pkg::DATA_W-1:0] right_i,
  input  logic signed [deq_pkg::DATA_W-1:0] head_i,
  input  logic signed [deq_pkg::DATA_W-1:0] tail_i,
  output logic signed [deq_pkg::DATA_W-1:0] data_o
);
  import deq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]         idx_ext;

  assign idx_ext = CNT_W'(idx_i);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      CMD_PUSH_FRONT: data_d = (idx_ext == '0) ? value_i : left_i;
      CMD_PUSH_BACK: begin
        if (idx_ext == ctrl_i.count) data_d = value_i;
      end
      CMD_POP_FRONT:  data_d = right_i;
      CMD_ROT_FWD: begin
        // wrap the front entry around to the back of the window
        if (idx_ext == ctrl_i.last_idx) data_d = head_i;
        else if (idx_ext < ctrl_i.last_idx) data_d = right_i;
      end
      CMD_ROT_BWD: begin
        if (idx_ext == '0) data_d = tail_i;
        else if (idx_ext < ctrl_i.count) data_d = left_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
